/* src/svg_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// svg_pkg
// Shared types and constants of the sphere vertex generator.
// ----------------------------------------------------------------------------
package svg_pkg;

  localparam int CNT_W   = 11;
  localparam int CRD_W   = 16;
  localparam int TEX_W   = 17;
  localparam int PH_W    = 32;
  localparam int CW      = 34;
  localparam int ATAN_N  = 32;

  localparam logic [CW-1:0] GAIN_Q30 = 34'sd652032874;
  localparam logic [PH_W-1:0] HALF_TURN = 32'h8000_0000;

  localparam logic [CNT_W-1:0] SEG_RST  = 11'd16;
  localparam logic [CNT_W-1:0] RING_RST = 11'd16;

  localparam logic [0:0] REG_SEG  = 1'b0;
  localparam logic [0:0] REG_RING = 1'b1;

  typedef struct packed {
    logic [CNT_W-1:0] ring_index;
    logic [CNT_W-1:0] segment_index;
  } in_item_t;

  typedef struct packed {
    logic signed [CRD_W-1:0] pos_x;
    logic signed [CRD_W-1:0] pos_y;
    logic signed [CRD_W-1:0] pos_z;
    logic [TEX_W-1:0]        tex_u;
    logic [TEX_W-1:0]        tex_v;
    logic                    index_clamped;
  } out_item_t;

  // Classified item handed from the front part to the back part
  typedef struct packed {
    logic [CNT_W-1:0] ring;
    logic [CNT_W-1:0] seg;
    logic [CNT_W-1:0] rc;
    logic [CNT_W-1:0] sc;
    logic             clamped;
  } job_t;

  function automatic logic [CW-1:0] atan_turns(input logic [4:0] i);
    logic [CW-1:0] r;
    case (i)
      5'd0: r = 34'd536870912;  5'd1: r = 34'd316933406;
      5'd2: r = 34'd167458907;  5'd3: r = 34'd85004756;
      5'd4: r = 34'd42667331;   5'd5: r = 34'd21354465;
      5'd6: r = 34'd10679838;   5'd7: r = 34'd5340245;
      5'd8: r = 34'd2670163;    5'd9: r = 34'd1335087;
      5'd10: r = 34'd667544;    5'd11: r = 34'd333772;
      5'd12: r = 34'd166886;    5'd13: r = 34'd83443;
      5'd14: r = 34'd41722;     5'd15: r = 34'd20861;
      5'd16: r = 34'd10430;     5'd17: r = 34'd5215;
      5'd18: r = 34'd2608;      5'd19: r = 34'd1304;
      5'd20: r = 34'd652;       5'd21: r = 34'd326;
      5'd22: r = 34'd163;       5'd23: r = 34'd81;
      5'd24: r = 34'd41;        5'd25: r = 34'd20;
      5'd26: r = 34'd10;        5'd27: r = 34'd5;
      5'd28: r = 34'd3;         5'd29: r = 34'd1;
      5'd30: r = 34'd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* src/svg_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// svg_front
// Accepts items, clamps counts and indices, and queues jobs for the back end.
// ----------------------------------------------------------------------------
module svg_front #(
  parameter int MAX_DIVISIONS = 1024
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire svg_pkg::in_item_t  in_data,
  input  wire [svg_pkg::CNT_W-1:0] seg_cnt,
  input  wire [svg_pkg::CNT_W-1:0] ring_cnt,
  output logic                    job_valid,
  input  wire                     job_ready,
  output svg_pkg::job_t           job_data
);
  localparam int CW = svg_pkg::CNT_W;
  localparam int DEPTH = 4;
  localparam logic [CW-1:0] MAXC =
    (MAX_DIVISIONS > 2047) ? {CW{1'b1}} : CW'(MAX_DIVISIONS);

  svg_pkg::job_t q_r [DEPTH];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic [CW-1:0] rc, sc, rg, sg;
  logic clamp;
  svg_pkg::job_t jn;
  logic push, pop;

  function automatic logic [CW-1:0] eff(input logic [CW-1:0] r);
    logic [CW-1:0] v;
    if (r == '0) v = CW'(1);
    else if (r > MAXC) v = MAXC;
    else v = r;
    return v;
  endfunction

  always_comb begin
    rc = eff(ring_cnt);
    sc = eff(seg_cnt);
    rg = in_data.ring_index;
    sg = in_data.segment_index;
    clamp = 1'b0;
    if (rg > rc) begin
      rg = rc;
      clamp = 1'b1;
    end
    if (sg > sc) begin
      sg = sc;
      clamp = 1'b1;
    end
    jn = '{ring: rg, seg: sg, rc: rc, sc: sc, clamped: clamp};
  end

  assign in_ready  = (cnt_r != 3'(DEPTH));
  assign job_valid = (cnt_r != '0);
  assign job_data  = q_r[rp_r];
  assign push = in_valid && in_ready;
  assign pop  = job_valid && job_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 2'd1;
      if (pop) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(push) - 3'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= jn;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'(DEPTH)) else $error("queue overflow");
  a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 3'(DEPTH)) |-> !push) else $error("push into full queue");
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 3'd1) else $error("count slip");
endmodule
`default_nettype wire

/* src/svg_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// svg_div
// Pipelined restoring divider, one quotient bit per stage, with side data.
// ----------------------------------------------------------------------------
module svg_div #(
  parameter int NW = 44,
  parameter int DW = 11,
  parameter int SW = 1
) (
  input  wire           clk,
  input  wire           en,
  input  wire [NW-1:0]  num,
  input  wire [DW-1:0]  den,
  input  wire [SW-1:0]  side_in,
  output logic [NW-1:0] quo,
  output logic [SW-1:0] side_out
);
  logic [NW-1:0] q_r [1:NW];
  logic [DW:0]   rm_r [1:NW];
  logic [DW-1:0] d_r [1:NW];
  logic [SW-1:0] s_r [1:NW];

  for (genvar k = 0; k < NW; k++) begin : g_st
    logic [NW-1:0] qi;
    logic [DW:0]   ri;
    logic [DW-1:0] di;
    logic [SW-1:0] si;
    logic [DW+1:0] t;
    logic ge;
    logic [NW-1:0] qn;

    if (k == 0) begin : g_first
      assign qi = num;
      assign ri = '0;
      assign di = den;
      assign si = side_in;
    end else begin : g_next
      assign qi = q_r[k];
      assign ri = rm_r[k];
      assign di = d_r[k];
      assign si = s_r[k];
    end

    assign t  = {ri, qi[NW-1-k]};
    assign ge = t >= {2'b00, di};

    // replace the consumed numerator bit by the quotient bit
    always_comb begin
      qn = qi;
      qn[NW-1-k] = ge;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rm_r[k+1] <= ge ? (DW+1)'(t - {2'b00, di}) : (DW+1)'(t);
        q_r[k+1]  <= qn;
        d_r[k+1]  <= di;
        s_r[k+1]  <= si;
      end
    end
  end

  assign quo = q_r[NW];
  assign side_out = s_r[NW];
endmodule
`default_nettype wire

/* src/svg_cordic.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// svg_cordic
// Pipelined rotation CORDIC: turn phase in, cosine and sine in Q4.30 out.
// ----------------------------------------------------------------------------
module svg_cordic #(
  parameter int ITER = 16,
  parameter int SW = 1
) (
  input  wire                       clk,
  input  wire                       en,
  input  wire [svg_pkg::PH_W-1:0]   phase,
  input  wire [SW-1:0]              side_in,
  output logic signed [svg_pkg::CW-1:0] cos_o,
  output logic signed [svg_pkg::CW-1:0] sin_o,
  output logic [SW-1:0]             side_out
);
  localparam int CW = svg_pkg::CW;
  localparam int N = (ITER > 32) ? 32 : ITER;

  logic signed [CW-1:0] x_r [N+1];
  logic signed [CW-1:0] y_r [N+1];
  logic signed [CW-1:0] z_r [N+1];
  logic f_r [N+1];
  logic [SW-1:0] s_r [N+1];
  logic signed [CW-1:0] z0;
  logic fl0;

  always_comb begin
    z0  = CW'(signed'(phase));
    fl0 = 1'b0;
    if (z0 > CW'(64'sd1073741824)) begin
      z0 = z0 - CW'(64'sd2147483648);
      fl0 = 1'b1;
    end else if (z0 < -CW'(64'sd1073741824)) begin
      z0 = z0 + CW'(64'sd2147483648);
      fl0 = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= svg_pkg::GAIN_Q30;
      y_r[0] <= '0;
      z_r[0] <= z0;
      f_r[0] <= fl0;
      s_r[0] <= side_in;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_it
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[i][CW-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - svg_pkg::atan_turns(5'(i));
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + svg_pkg::atan_turns(5'(i));
        end
        f_r[i+1] <= f_r[i];
        s_r[i+1] <= s_r[i];
      end
    end
  end

  assign cos_o = f_r[N] ? -x_r[N] : x_r[N];
  assign sin_o = f_r[N] ? -y_r[N] : y_r[N];
  assign side_out = s_r[N];
endmodule
`default_nettype wire

/* src/svg_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// svg_back
// Phase division, CORDIC, products and rounding; a stall-enabled pipeline
// with a skid-free output register behind it.
// ----------------------------------------------------------------------------
module svg_back #(
  parameter int COORD_FRAC_BITS = 15,
  parameter int ANGLE_ITERATIONS = 16
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    job_valid,
  output logic                   job_ready,
  input  wire svg_pkg::job_t     job_data,
  output logic                   out_valid,
  input  wire                    out_ready,
  output svg_pkg::out_item_t     out_data
);
  localparam int CN = svg_pkg::CNT_W;
  localparam int CW = svg_pkg::CW;
  localparam int ITN = (ANGLE_ITERATIONS > 32) ? 32 : ANGLE_ITERATIONS;
  localparam int RNW = 43;
  localparam int SNW = 44;
  localparam int TNW = 28;
  localparam int TSW = 2*svg_pkg::TEX_W + 1;
  localparam int LAT = SNW + ITN + 3;
  localparam int F = COORD_FRAC_BITS;

  logic en;
  logic [LAT-1:0] v_r;

  // Pipeline moves whenever its last stage is empty or being taken
  assign en = !v_r[LAT-1] || !out_valid || out_ready;
  assign job_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (en) v_r <= {v_r[LAT-2:0], job_valid};
  end

  // Phase and texture numerators
  logic [RNW-1:0] rnum;
  logic [SNW-1:0] snum;
  logic [TNW-1:0] unum, vnum;
  assign rnum = {1'b0, job_data.ring, 31'd0} + RNW'(job_data.rc >> 1);
  assign snum = {1'b0, job_data.seg, 32'd0} + SNW'(job_data.sc >> 1);
  assign unum = {1'b0, CN'(job_data.sc - job_data.seg), 16'd0}
              + TNW'(job_data.sc >> 1);
  assign vnum = {1'b0, job_data.ring, 16'd0} + TNW'(job_data.rc >> 1);

  logic [RNW-1:0] rq;
  logic [SNW-1:0] sq;
  logic [TNW-1:0] uq, vq;
  logic cl_d, cl_d2;

  svg_div #(.NW(RNW), .DW(CN), .SW(1)) u_rdiv (
    .clk(clk), .en(en), .num(rnum), .den(job_data.rc),
    .side_in(job_data.clamped), .quo(rq), .side_out(cl_d));
  svg_div #(.NW(SNW), .DW(CN), .SW(1)) u_sdiv (
    .clk(clk), .en(en), .num(snum), .den(job_data.sc),
    .side_in(1'b0), .quo(sq), .side_out(cl_d2));
  svg_div #(.NW(TNW), .DW(CN), .SW(1)) u_udiv (
    .clk(clk), .en(en), .num(unum), .den(job_data.sc),
    .side_in(1'b0), .quo(uq), .side_out());
  svg_div #(.NW(TNW), .DW(CN), .SW(1)) u_vdiv (
    .clk(clk), .en(en), .num(vnum), .den(job_data.rc),
    .side_in(1'b0), .quo(vq), .side_out());

  // Align the shorter dividers and the ring divider to the segment one
  logic [RNW-1:0] rq_r;
  logic cl_r;
  logic [TSW-1:0] tx_r [SNW-TNW];
  logic [TSW-1:0] tx_a;
  always_ff @(posedge clk) begin
    if (en) begin
      rq_r <= rq;
      cl_r <= cl_d | cl_d2;
      tx_r[0] <= {svg_pkg::TEX_W'(uq), svg_pkg::TEX_W'(vq), 1'b0};
    end
  end
  for (genvar k = 1; k < SNW-TNW; k++) begin : g_tx
    always_ff @(posedge clk) if (en) tx_r[k] <= tx_r[k-1];
  end
  assign tx_a = tx_r[SNW-TNW-1];

  logic signed [CW-1:0] rcos, rsin, scos, ssin;
  logic [TSW-1:0] side_rc, side_sc;
  svg_cordic #(.ITER(ITN), .SW(TSW)) u_rcor (
    .clk(clk), .en(en), .phase(rq_r[31:0]),
    .side_in({tx_a[TSW-1:1], cl_r}),
    .cos_o(rcos), .sin_o(rsin), .side_out(side_rc));
  svg_cordic #(.ITER(ITN), .SW(TSW)) u_scor (
    .clk(clk), .en(en), .phase(sq[31:0]),
    .side_in('0), .cos_o(scos), .sin_o(ssin), .side_out(side_sc));

  logic signed [2*CW-1:0] px_r, pz_r;
  logic signed [CW-1:0] py_r;
  logic [TSW-1:0] sd_r;
  always_ff @(posedge clk) begin
    if (en) begin
      px_r <= rsin * ssin;
      pz_r <= rsin * scos;
      py_r <= rcos;
      sd_r <= side_rc | side_sc;
    end
  end

  function automatic logic [15:0] rnd(input logic signed [2*CW-1:0] v, input int sh);
    logic signed [2*CW-1:0] t;
    logic signed [2*CW-1:0] hi, lo;
    hi = (2*CW)'((64'sd1 <<< F) - 1);
    lo = -(2*CW)'(64'sd1 <<< F);
    t = v;
    if (sh > 0) t = (v + ((2*CW)'(1) <<< (sh - 1))) >>> sh;
    if (t > hi) t = hi;
    if (t < lo) t = lo;
    return t[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en && v_r[LAT-2]) begin
      out_data.pos_x <= rnd(px_r, 60 - F);
      out_data.pos_y <= rnd((2*CW)'(py_r), 30 - F);
      out_data.pos_z <= rnd(pz_r, 60 - F);
      out_data.tex_u <= sd_r[TSW-1 -: svg_pkg::TEX_W];
      out_data.tex_v <= sd_r[svg_pkg::TEX_W:1];
      out_data.index_clamped <= sd_r[0];
    end
  end
  assign out_valid = v_r[LAT-1];

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_data))
    else $error("result lost under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !job_ready) else $error("accept during stall");
  a_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> job_ready) else $error("needless stall");
endmodule
`default_nettype wire

/* src/sphere_vertex_generator_unit.sv */
`default_nettype none
// From acceptance to result an item passes the queue, the bit-per-stage phase
//   divider, one CORDIC input stage plus one per iteration of ANGLE_ITERATIONS
//   (capped at 32), the product register and the rounding register.
// Throughput: one vertex per cycle unless the output stalls; a four-entry queue
//   decouples front and back. Reset: synchronous active-low rst_n empties the
//   queue and pipeline and sets both counts to 16.
// ----------------------------------------------------------------------------
// sphere_vertex_generator_unit
// UV sphere vertex generator with APB-style count registers.
// ----------------------------------------------------------------------------
module sphere_vertex_generator_unit #(
  parameter int MAX_DIVISIONS = 1024,
  parameter int COORD_FRAC_BITS = 15,
  parameter int ANGLE_ITERATIONS = 16
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire svg_pkg::in_item_t   in_data,
  output logic                     out_valid,
  input  wire                      out_ready,
  output svg_pkg::out_item_t       out_data,
  input  wire                      cfg_psel,
  input  wire                      cfg_penable,
  input  wire                      cfg_pwrite,
  input  wire [2:0]                cfg_paddr,
  input  wire [31:0]               cfg_pwdata,
  output logic [31:0]              cfg_prdata,
  output logic                     cfg_pready
);
  logic [svg_pkg::CNT_W-1:0] seg_r, ring_r;
  logic wr;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[1:0] == 2'b00);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r  <= svg_pkg::SEG_RST;
      ring_r <= svg_pkg::RING_RST;
    end else if (wr) begin
      case (cfg_paddr[2])
        svg_pkg::REG_SEG:  seg_r  <= cfg_pwdata[svg_pkg::CNT_W-1:0];
        default:           ring_r <= cfg_pwdata[svg_pkg::CNT_W-1:0];
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      svg_pkg::REG_SEG:  cfg_prdata = 32'(seg_r);
      svg_pkg::REG_RING: cfg_prdata = 32'(ring_r);
      default:           cfg_prdata = '0;
    endcase
  end

  logic job_valid, job_ready;
  svg_pkg::job_t job_data;

  svg_front #(.MAX_DIVISIONS(MAX_DIVISIONS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .seg_cnt(seg_r), .ring_cnt(ring_r),
    .job_valid(job_valid), .job_ready(job_ready), .job_data(job_data));

  svg_back #(.COORD_FRAC_BITS(COORD_FRAC_BITS), .ANGLE_ITERATIONS(ANGLE_ITERATIONS))
  u_back (
    .clk(clk), .rst_n(rst_n), .job_valid(job_valid), .job_ready(job_ready),
    .job_data(job_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data));
endmodule
`default_nettype wire
